FILE: sv/ise_pkg.sv
// shared types and codes for the interval set engine
package ise_pkg;

   localparam int VW = 63;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]    kind;
      logic [4:0]    source_id;
      logic [VW-1:0] range_start;
      logic [VW-1:0] range_end;
      logic [VW-1:0] query_number;
   } req_type;

   typedef struct packed {
      logic       is_member;
      logic [1:0] status;
      logic [4:0] interval_count;
   } rsp_type;

endpackage

FILE: sv/ise_ram.sv
// generic single write port ram with registered read
module ise_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/interval_set_engine.sv
// top level of the interval set engine: table walk sequencer over a double-banked ram
//
//  channel | direction | word
//  req     | in        | ise_pkg::req_type  (kind, source, range, query number)
//  rsp     | out       | ise_pkg::rsp_type  (member flag, status, interval count)
//
// an item walks the cnt ranges stored for the source, then finishes in S_FIN and S_DONE;
// a clear, a bad source or an empty add or remove range is settled at the check and goes to S_DONE
// the walk reads one entry a cycle from the ram, but an entry that yields two writes holds it for S_W2
// each source has two banks: the walk reads one and writes the other, a flip commits it
// reset clears the interval counts and bank selects at once, no clearing pass
// a finished word waits until the output register is free; the next word is taken after that
module interval_set_engine #(
   parameter int NUM_SOURCES = 16,
   parameter int MAX_RANGES  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ise_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ise_pkg::rsp_type rsp_data
);

   localparam int VW    = ise_pkg::VW;
   localparam int DW    = 2 * VW;
   localparam int SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int CW    = $clog2(MAX_RANGES + 1);
   localparam int KW    = $clog2(MAX_RANGES);
   localparam int SAW   = $clog2(NUM_SOURCES * MAX_RANGES);
   localparam int AW    = SAW + 1;
   localparam int DEPTH = 2 * NUM_SOURCES * MAX_RANGES;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_PROC = 3'd2;
   localparam logic [2:0] S_W2   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]       state_ff, state_in;
   ise_pkg::req_type req_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [VW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic             placed_ff, placed_in;
   logic             full_ff, full_in;
   logic             member_ff, member_in;
   logic [DW-1:0]    w2_ff, w2_in;
   ise_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ise_pkg::rsp_type rsp_ff;
   logic [CW-1:0]    counts_ff [NUM_SOURCES];
   logic             bank_ff [NUM_SOURCES];

   logic [SW-1:0]    src;
   logic             bad_src;
   logic             bank;
   logic [SAW-1:0]   base;
   logic             we;
   logic [AW-1:0]    waddr, raddr;
   logic [DW-1:0]    wdata, rdata;
   logic [VW-1:0]    ent_s, ent_e;
   logic             clear_all, commit;
   logic [CW-1:0]    commit_cnt;
   logic             rsp_free;
   logic             w1_v, w2_v;
   logic [DW-1:0]    w1_d, w2_d;
   logic             push_fin;

   assign src      = SW'(req_ff.source_id - 5'd1);
   assign bad_src  = (req_ff.source_id == 5'd0) || (32'(req_ff.source_id) > NUM_SOURCES);
   assign bank     = bank_ff[src];
   assign base     = SAW'(src * MAX_RANGES);
   assign ent_s    = rdata[DW-1:VW];
   assign ent_e    = rdata[VW-1:0];
   assign raddr    = {bank, SAW'(base + SAW'(k_in[KW-1:0]))};
   assign waddr    = {~bank, SAW'(base + SAW'(n_ff[KW-1:0]))};
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   ise_ram #(
      .WIDTH(DW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      placed_in    = placed_ff;
      full_in      = full_ff;
      member_in    = member_ff;
      w2_in        = w2_ff;
      res_in       = res_ff;
      we           = 1'b0;
      wdata        = '0;
      clear_all    = 1'b0;
      commit       = 1'b0;
      commit_cnt   = n_ff;
      w1_v         = 1'b0;
      w2_v         = 1'b0;
      w1_d         = '0;
      w2_d         = '0;
      push_fin     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            k_in      = '0;
            n_in      = '0;
            lo_in     = req_ff.range_start;
            hi_in     = req_ff.range_end;
            placed_in = 1'b0;
            full_in   = 1'b0;
            member_in = 1'b0;
            res_in    = '0;
            state_in  = S_DONE;
            if (req_ff.kind == ise_pkg::KIND_CLEAR) begin
               clear_all = 1'b1;
            end else if (bad_src) begin
               res_in.status = ise_pkg::STAT_BAD;
            end else begin
               cnt_in = counts_ff[src];
               if (req_ff.kind != ise_pkg::KIND_QUERY &&
                   req_ff.range_start >= req_ff.range_end) begin
                  res_in.status         = ise_pkg::STAT_BAD;
                  res_in.interval_count = 5'(counts_ff[src]);
               end else if (counts_ff[src] == '0) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_PROC;
               end
            end
         end
         S_PROC: begin
            case (req_ff.kind)
               ise_pkg::KIND_ADD: begin
                  if (ent_e < lo_ff) begin
                     w1_v = 1'b1;
                     w1_d = rdata;
                  end else if (ent_s > hi_ff) begin
                     w1_v = 1'b1;
                     if (!placed_ff) begin
                        w1_d      = {lo_ff, hi_ff};
                        w2_v      = 1'b1;
                        w2_d      = rdata;
                        placed_in = 1'b1;
                     end else begin
                        w1_d = rdata;
                     end
                  end else begin
                     // overlapping or touching: widen the new range
                     if (ent_s < lo_ff) lo_in = ent_s;
                     if (ent_e > hi_ff) hi_in = ent_e;
                  end
               end
               ise_pkg::KIND_REMOVE: begin
                  if (ent_s < lo_ff) begin
                     w1_v = 1'b1;
                     w1_d = {ent_s, (ent_e < lo_ff) ? ent_e : lo_ff};
                  end
                  if (ent_e > hi_ff) begin
                     if (ent_s < lo_ff) begin
                        w2_v = 1'b1;
                        w2_d = {(ent_s > hi_ff) ? ent_s : hi_ff, ent_e};
                     end else begin
                        w1_v = 1'b1;
                        w1_d = {(ent_s > hi_ff) ? ent_s : hi_ff, ent_e};
                     end
                  end
               end
               default: begin
                  if (req_ff.query_number >= ent_s && req_ff.query_number < ent_e) begin
                     member_in = 1'b1;
                  end
               end
            endcase
            if (w1_v) begin
               if (n_ff < CW'(MAX_RANGES)) begin
                  we    = 1'b1;
                  wdata = w1_d;
                  n_in  = n_ff + CW'(1);
               end else begin
                  full_in = 1'b1;
               end
            end
            if (w2_v) begin
               w2_in    = w2_d;
               state_in = S_W2;
            end else begin
               k_in = k_ff + CW'(1);
               if (k_in == cnt_ff) begin
                  state_in = S_FIN;
               end
            end
         end
         S_W2: begin
            if (n_ff < CW'(MAX_RANGES)) begin
               we    = 1'b1;
               wdata = w2_ff;
               n_in  = n_ff + CW'(1);
            end else begin
               full_in = 1'b1;
            end
            k_in     = k_ff + CW'(1);
            state_in = (k_in == cnt_ff) ? S_FIN : S_PROC;
         end
         S_FIN: begin
            res_in = '0;
            state_in = S_DONE;
            if (req_ff.kind == ise_pkg::KIND_QUERY) begin
               res_in.is_member      = member_ff;
               res_in.interval_count = 5'(cnt_ff);
            end else begin
               push_fin = (req_ff.kind == ise_pkg::KIND_ADD) && !placed_ff;
               if (push_fin && n_ff < CW'(MAX_RANGES)) begin
                  we         = 1'b1;
                  wdata      = {lo_ff, hi_ff};
                  commit_cnt = n_ff + CW'(1);
               end
               if (full_ff || (push_fin && n_ff == CW'(MAX_RANGES))) begin
                  res_in.status         = ise_pkg::STAT_FULL;
                  res_in.interval_count = 5'(cnt_ff);
               end else begin
                  commit                = 1'b1;
                  res_in.interval_count = 5'(commit_cnt);
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            counts_ff[i] <= '0;
            bank_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_all) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
               counts_ff[i] <= '0;
            end
         end else if (commit) begin
            counts_ff[src] <= commit_cnt;
            bank_ff[src]   <= ~bank_ff[src];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_ff <= res_ff;
      end
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      placed_ff <= placed_in;
      full_ff   <= full_in;
      member_ff <= member_in;
      w2_ff     <= w2_in;
      res_ff    <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROC || state_ff == S_W2) |-> (k_ff < cnt_ff))
      else $error("walk index beyond table count");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROC || state_ff == S_W2 || state_ff == S_FIN)
         |-> (n_ff <= CW'(MAX_RANGES)))
      else $error("output fill beyond table size");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHK))
      else $error("accepted word did not start a check");
`endif

endmodule

FILE: verif/interval_set_engine_tb.sv
// self-checking testbench for the interval set engine: directed and random add, remove, query, clear
`timescale 1ns / 1ps
module interval_set_engine_tb;

   localparam int NSRC = 16;
   localparam int NRNG = 16;
   localparam int WATCHDOG = 20000;
   localparam int VW = ise_pkg::VW;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ise_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ise_pkg::rsp_type rsp_data;

   interval_set_engine #(.NUM_SOURCES(NSRC), .MAX_RANGES(NRNG)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // shadow copy of the interval tables
   logic [VW-1:0] tab_lo [NSRC][NRNG];
   logic [VW-1:0] tab_hi [NSRC][NRNG];
   int            tab_cnt [NSRC];

   ise_pkg::rsp_type expected_words[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;      // no idling
   bit      hold_rsp = 1'b0;   // long receiver hold-off
   bit      stream_hold = 1'b0;

   task automatic report(input string what, input ise_pkg::rsp_type got,
                         input ise_pkg::rsp_type want);
      $display("mismatch %s: got m=%0d s=%0d c=%0d want m=%0d s=%0d c=%0d", what,
               got.is_member, got.status, got.interval_count,
               want.is_member, want.status, want.interval_count);
      fail_count++;
   endtask

   function automatic ise_pkg::rsp_type predict_interval_op(input ise_pkg::req_type r);
      ise_pkg::rsp_type o;
      int            src, n;
      bit            placed;
      logic [VW-1:0] lo, hi, s, e;
      logic [VW-1:0] ns [NRNG+1];
      logic [VW-1:0] ne [NRNG+1];
      o = '0;
      n = 0;
      placed = 1'b0;
      lo = r.range_start;
      hi = r.range_end;
      if (r.kind == ise_pkg::KIND_CLEAR) begin
         for (int i = 0; i < NSRC; i++) tab_cnt[i] = 0;
         return o;
      end
      if (r.source_id == 0 || r.source_id > NSRC) begin
         o.status = ise_pkg::STAT_BAD;
         return o;
      end
      src = int'(r.source_id) - 1;
      if (r.kind == ise_pkg::KIND_QUERY) begin
         for (int k = 0; k < tab_cnt[src]; k++) begin
            if (r.query_number < tab_lo[src][k]) break;
            if (r.query_number < tab_hi[src][k]) begin
               o.is_member = 1'b1;
               break;
            end
         end
      end else if (lo >= hi) begin
         o.status = ise_pkg::STAT_BAD;
      end else if (r.kind == ise_pkg::KIND_ADD) begin
         for (int k = 0; k < tab_cnt[src]; k++) begin
            s = tab_lo[src][k];
            e = tab_hi[src][k];
            if (e < lo) begin
               ns[n] = s; ne[n] = e; n++;
            end else if (s > hi) begin
               if (!placed) begin
                  ns[n] = lo; ne[n] = hi; n++; placed = 1'b1;
               end
               ns[n] = s; ne[n] = e; n++;
            end else begin
               if (s < lo) lo = s;
               if (e > hi) hi = e;
            end
            if (n > NRNG) o.status = ise_pkg::STAT_FULL;
            if (o.status != ise_pkg::STAT_OK) break;
         end
         if (o.status == ise_pkg::STAT_OK && !placed) begin
            if (n >= NRNG) o.status = ise_pkg::STAT_FULL;
            else begin
               ns[n] = lo; ne[n] = hi; n++;
            end
         end
         if (o.status == ise_pkg::STAT_OK && n > NRNG) o.status = ise_pkg::STAT_FULL;
      end else begin
         for (int k = 0; k < tab_cnt[src]; k++) begin
            s = tab_lo[src][k];
            e = tab_hi[src][k];
            if (s < lo) begin
               if (n >= NRNG) begin o.status = ise_pkg::STAT_FULL; break; end
               ns[n] = s; ne[n] = (e < lo) ? e : lo; n++;
            end
            if (e > hi) begin
               if (n >= NRNG) begin o.status = ise_pkg::STAT_FULL; break; end
               ns[n] = (s > hi) ? s : hi; ne[n] = e; n++;
            end
         end
      end
      if ((r.kind == ise_pkg::KIND_ADD || r.kind == ise_pkg::KIND_REMOVE) && lo < hi &&
          o.status == ise_pkg::STAT_OK) begin
         for (int k = 0; k < n; k++) begin
            tab_lo[src][k] = ns[k];
            tab_hi[src][k] = ne[k];
         end
         tab_cnt[src] = n;
      end
      o.interval_count = 5'(tab_cnt[src]);
      return o;
   endfunction

   // valid stays up between back to back words and drops only for an idle burst
   task automatic send_word(input ise_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(predict_interval_op(r));
   endtask

   task automatic send_op(input logic [1:0] k, input int sid, input logic [VW-1:0] lo,
                          input logic [VW-1:0] hi, input logic [VW-1:0] q);
      ise_pkg::req_type r;
      r.kind = k;
      r.source_id = 5'(sid);
      r.range_start = lo;
      r.range_end = hi;
      r.query_number = q;
      send_word(r);
   endtask

   function automatic logic [VW-1:0] rand_value(input bit wide);
      if (wide) return VW'({$urandom, $urandom});
      return VW'($urandom_range(1, 200));
   endfunction

   // receiver: random stalls, optional long hold
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp) rsp_ready <= 1'b0;
      else if (quiet) rsp_ready <= 1'b1;
      else if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         idle_cycles <= $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   // result checker
   always @(posedge clock) begin
      ise_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report("unexpected word", rsp_data, '0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.is_member !== want.is_member) report("is_member", rsp_data, want);
            if (rsp_data.status !== want.status) report("status", rsp_data, want);
            if (rsp_data.interval_count !== want.interval_count)
               report("interval_count", rsp_data, want);
         end
      end
   end

   // watchdog on cycles with no handshake
   int stall_count = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || stream_hold)
         stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_op(ise_pkg::KIND_QUERY, 1, 0, 0, 5);
      send_op(ise_pkg::KIND_ADD, 1, 10, 20, 0);
      send_op(ise_pkg::KIND_ADD, 1, 30, 40, 0);
      send_op(ise_pkg::KIND_ADD, 1, 20, 30, 0);            // touches both, merges
      send_op(ise_pkg::KIND_QUERY, 1, 0, 0, 39);
      send_op(ise_pkg::KIND_QUERY, 1, 0, 0, 40);
      send_op(ise_pkg::KIND_REMOVE, 1, 15, 25, 0);         // split
      send_op(ise_pkg::KIND_REMOVE, 1, 1, 12, 0);          // truncate
      send_op(ise_pkg::KIND_REMOVE, 1, 25, 40, 0);         // delete
      send_op(ise_pkg::KIND_ADD, 0, 1, 2, 0);              // bad source
      send_op(ise_pkg::KIND_QUERY, 17, 0, 0, 1);
      send_op(ise_pkg::KIND_ADD, 31, 1, 2, 0);
      send_op(ise_pkg::KIND_ADD, 2, 5, 5, 0);              // empty range
      send_op(ise_pkg::KIND_REMOVE, 2, 9, 3, 0);
      send_op(ise_pkg::KIND_ADD, 16, 1, {VW{1'b1}}, {VW{1'b1}});
      send_op(ise_pkg::KIND_QUERY, 16, {VW{1'b1}}, 0, {VW{1'b1}} - 1);
      send_op(ise_pkg::KIND_QUERY, 16, 0, 0, {VW{1'b1}});
      for (int i = 0; i < NRNG; i++)
         send_op(ise_pkg::KIND_ADD, 3, VW'(10 * i + 1), VW'(10 * i + 5), 0);
      send_op(ise_pkg::KIND_ADD, 3, 500, 600, 0);          // full on add
      send_op(ise_pkg::KIND_REMOVE, 3, 2, 3, 0);           // full on split
      send_op(ise_pkg::KIND_ADD, 3, 1, 200, 0);
      send_op(ise_pkg::KIND_CLEAR, 0, {VW{1'b1}}, {VW{1'b1}}, {VW{1'b1}});
      send_op(ise_pkg::KIND_QUERY, 16, 0, 0, 100);
   endtask

   task automatic test_random(input int count);
      logic [1:0]    k;
      logic [VW-1:0] a, b;
      bit            wide;
      int            sid;
      int            pick;
      for (int i = 0; i < count; i++) begin
         wide = ($urandom_range(0, 9) == 0);
         a = rand_value(wide);
         b = rand_value(wide);
         if ($urandom_range(0, 9) != 0 && a > b) begin
            {a, b} = {b, a};
         end
         if ($urandom_range(0, 9) != 0 && a == b) b = a + 1;
         sid = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
         pick = $urandom_range(0, 99);
         if (pick < 45) k = ise_pkg::KIND_ADD;
         else if (pick < 70) k = ise_pkg::KIND_REMOVE;
         else if (pick < 99) k = ise_pkg::KIND_QUERY;
         else k = ise_pkg::KIND_CLEAR;
         send_op(k, sid, a, b, rand_value(wide));
      end
   endtask

   task automatic test_backpressure();
      int hold_len;
      hold_len = 300;
      hold_rsp = 1'b1;
      stream_hold = 1'b1;
      fork
         begin
            repeat (hold_len) @(posedge clock);
            hold_rsp = 1'b0;
            stream_hold = 1'b0;
         end
         test_random(20);
      join
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NSRC; i++) tab_cnt[i] = 0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1300);
      quiet = 1'b1;
      test_random(100);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
